// File: hw/rtl/dlrs_pkg.sv
// Package with the shared types and constants of the decimal radix sorter.
`timescale 1ns / 1ps
package dlrs_pkg;
   localparam int VALUE_W = 31;
   localparam int BUCKETS = 10;
   localparam int DIGIT_W = 4;
   localparam int PASS_W = 4;
   localparam logic [PASS_W-1:0] DIGIT_LIMIT = 4'd10;
   localparam logic [PASS_W-1:0] PASSES_RESET = 4'd10;
   localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
   localparam int RECIP_SHIFT = 35;
   localparam int CSR_AW = 3;
   localparam logic [0:0] REG_DIGIT_PASSES = 1'b0;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_COUNT,
      ST_PREFIX,
      ST_SCATTER,
      ST_OUT_READ,
      ST_OUT_LOAD,
      ST_OUT_SEND
   } state_type;
endpackage

// File: hw/rtl/dlrs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module dlrs_ram #(
   parameter int WIDTH = 62,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: hw/rtl/decimal_lsd_radix_sorter.sv
// Top level of the decimal least-significant-digit radix sorter.
`timescale 1ns / 1ps
// The block takes a batch of up to MAX_ITEMS values, one per cycle, and the transfer with
// tlast (or the one that fills the store) closes the batch. Each item is kept in one of two
// RAM banks together with its value divided by ten once per finished pass, so the digit of
// a pass is the remainder of that quotient. A pass reads the batch twice through a pipeline
// with one multiplier: once to count the ten buckets and once to scatter the items into the
// other bank, with a prefix step between them that forms the ten bucket start offsets. The
// number of passes is capped at ten. The sorted batch then leaves one result at a time:
// each is read from the RAM, loaded into the output register and held until it is
// transferred. No new batch is taken until the last result has been transferred.
module decimal_lsd_radix_sorter
   import dlrs_pkg::*;
#(
   parameter int MAX_ITEMS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // item_value[30:0], zero fill[31]
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // sorted_value[30:0], zero fill[31]
   output logic              rsp_tlast,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int EW = 2 * VALUE_W;

   state_type state_ff, state_in;

   logic [PASS_W-1:0]  passes_ff;
   logic [PASS_W-1:0]  passes_eff;
   logic [PASS_W-1:0]  pass_ff;
   logic               cur_ff;
   logic [CW-1:0]      cnt_ff;
   logic [CW-1:0]      rd_idx_ff;
   logic [DIGIT_W-1:0] bkt_ff;
   logic [CW-1:0]      acc_ff;
   logic [CW-1:0]      count_ff [BUCKETS];
   logic [CW-1:0]      start_ff [BUCKETS];

   logic               iss_v_ff, va_ff, vb_ff;
   logic [62:0]        prod_ff;
   logic [VALUE_W-1:0] val_a_ff, quot_a_ff, val_b_ff, quot_b_ff;
   logic [DIGIT_W-1:0] dig_ff;

   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_last_ff, rsp_valid_ff;

   logic               req_xfer, rsp_xfer, close_batch, issue, pipe_empty;
   logic               rd_idx_clr, rd_idx_inc, count_en, scat_en, load_en;
   logic [27:0]        qd;
   logic [DIGIT_W-1:0] ten_qd_lo, digit_b;
   logic [EW-1:0]      rd0, rd1, rd_entry, load_entry, scat_entry;
   logic [AW-1:0]      scat_addr;
   logic               we0, we1;
   logic [AW-1:0]      wa0, wa1;
   logic [EW-1:0]      wd0, wd1;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[CSR_AW-1:2] == REG_DIGIT_PASSES);
   assign csr_prdata = (csr_paddr[CSR_AW-1:2] == REG_DIGIT_PASSES)
                       ? {28'd0, passes_ff} : 32'd0;
   assign passes_eff = (passes_ff > DIGIT_LIMIT) ? DIGIT_LIMIT : passes_ff;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_valid_ff && rsp_tready;
   assign close_batch = req_tlast || (cnt_ff == CW'(MAX_ITEMS - 1));
   assign issue = (state_ff == ST_COUNT || state_ff == ST_SCATTER) && (rd_idx_ff < cnt_ff);
   assign pipe_empty = !issue && !iss_v_ff && !va_ff && !vb_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {1'b0, rsp_value_ff};
   assign rsp_tlast = rsp_last_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_xfer && close_batch) begin
               state_in = (passes_eff == '0) ? ST_OUT_READ : ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (pipe_empty) begin
               state_in = ST_PREFIX;
            end
         end
         ST_PREFIX: begin
            if (bkt_ff == DIGIT_W'(BUCKETS - 1)) begin
               state_in = ST_SCATTER;
            end
         end
         ST_SCATTER: begin
            if (pipe_empty) begin
               state_in = (pass_ff + 1'b1 >= passes_eff) ? ST_OUT_READ : ST_COUNT;
            end
         end
         ST_OUT_READ: state_in = ST_OUT_LOAD;
         ST_OUT_LOAD: state_in = ST_OUT_SEND;
         ST_OUT_SEND: begin
            if (rsp_xfer) begin
               state_in = rsp_last_ff ? ST_LOAD : ST_OUT_READ;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      load_en = 1'b0;
      count_en = 1'b0;
      scat_en = 1'b0;
      rd_idx_inc = 1'b0;
      rd_idx_clr = (state_in != state_ff)
                   && (state_in == ST_COUNT || state_in == ST_SCATTER
                       || (state_in == ST_OUT_READ && state_ff != ST_OUT_SEND));
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            load_en = req_xfer;
         end
         ST_COUNT: begin
            count_en = vb_ff;
            rd_idx_inc = issue;
         end
         ST_SCATTER: begin
            scat_en = vb_ff;
            rd_idx_inc = issue;
         end
         ST_OUT_SEND: rd_idx_inc = rsp_xfer;
         default: ;
      endcase
   end

   assign rd_entry = cur_ff ? rd1 : rd0;
   assign load_entry = {req_tdata[VALUE_W-1:0], req_tdata[VALUE_W-1:0]};
   assign scat_entry = {val_b_ff, quot_b_ff};
   assign scat_addr = start_ff[dig_ff][AW-1:0];

   assign we0 = (load_en && !cur_ff) || (scat_en && cur_ff);
   assign we1 = (load_en && cur_ff) || (scat_en && !cur_ff);
   assign wa0 = load_en ? cnt_ff[AW-1:0] : scat_addr;
   assign wa1 = wa0;
   assign wd0 = load_en ? load_entry : scat_entry;
   assign wd1 = wd0;

   dlrs_ram #(.WIDTH(EW), .DEPTH(MAX_ITEMS)) u_bank0 (
      .clock(clock), .wr_en(we0), .wr_addr(wa0), .wr_data(wd0),
      .rd_addr(rd_idx_ff[AW-1:0]), .rd_data(rd0)
   );

   dlrs_ram #(.WIDTH(EW), .DEPTH(MAX_ITEMS)) u_bank1 (
      .clock(clock), .wr_en(we1), .wr_addr(wa1), .wr_data(wd1),
      .rd_addr(rd_idx_ff[AW-1:0]), .rd_data(rd1)
   );

   assign qd = prod_ff[62:RECIP_SHIFT];
   assign ten_qd_lo = DIGIT_W'({qd[0], 3'b000}) + DIGIT_W'({qd[2:0], 1'b0});
   assign digit_b = quot_a_ff[DIGIT_W-1:0] - ten_qd_lo;

   always_ff @(posedge clock) begin
      prod_ff <= 63'(rd_entry[VALUE_W-1:0]) * 63'(RECIP_TEN);
      val_a_ff <= rd_entry[EW-1:VALUE_W];
      quot_a_ff <= rd_entry[VALUE_W-1:0];
      val_b_ff <= val_a_ff;
      quot_b_ff <= VALUE_W'(qd);
      dig_ff <= digit_b;
      if (state_ff == ST_OUT_LOAD) begin
         rsp_value_ff <= rd_entry[EW-1:VALUE_W];
         rsp_last_ff <= (rd_idx_ff + 1'b1 == cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         passes_ff <= PASSES_RESET;
         pass_ff <= '0;
         cur_ff <= 1'b0;
         cnt_ff <= '0;
         rd_idx_ff <= '0;
         bkt_ff <= '0;
         acc_ff <= '0;
         iss_v_ff <= 1'b0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < BUCKETS; b++) begin
            count_ff[b] <= '0;
            start_ff[b] <= '0;
         end
      end else begin
         state_ff <= state_in;
         iss_v_ff <= issue;
         va_ff <= iss_v_ff;
         vb_ff <= va_ff;
         if (csr_wr) begin
            passes_ff <= csr_pwdata[PASS_W-1:0];
         end
         if (load_en) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (rd_idx_clr) begin
            rd_idx_ff <= '0;
         end else if (rd_idx_inc) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
         if (count_en) begin
            count_ff[dig_ff] <= count_ff[dig_ff] + 1'b1;
         end
         if (state_ff == ST_PREFIX) begin
            start_ff[bkt_ff] <= acc_ff;
            count_ff[bkt_ff] <= '0;
            if (bkt_ff == DIGIT_W'(BUCKETS - 1)) begin
               bkt_ff <= '0;
               acc_ff <= '0;
            end else begin
               bkt_ff <= bkt_ff + 1'b1;
               acc_ff <= acc_ff + count_ff[bkt_ff];
            end
         end
         if (scat_en) begin
            start_ff[dig_ff] <= start_ff[dig_ff] + 1'b1;
         end
         if (state_ff == ST_SCATTER && pipe_empty) begin
            cur_ff <= !cur_ff;
            pass_ff <= pass_ff + 1'b1;
         end
         if (state_ff == ST_OUT_LOAD) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end
         if (rsp_xfer && rsp_last_ff) begin
            cnt_ff <= '0;
            pass_ff <= '0;
         end
      end
   end
endmodule

// File: hw/rtl/dlrs_checker.sv
// Port-level checker for the decimal radix sorter and its bind statement.
`timescale 1ns / 1ps
module dlrs_checker
   import dlrs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_pready
);
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("Stalled result changed.");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("Input taken while the sorted batch is being sent.");

   a_batch_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("Block not back to loading after the last result.");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("Configuration port stalled.");
endmodule

bind decimal_lsd_radix_sorter dlrs_checker u_dlrs_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
   .csr_pready(csr_pready)
);
